// ----- rtl/core/mcu_dec_pkg.sv -----
// Package with the item types, instruction kinds and opcode constants of the decoder.
`timescale 1ns / 1ps

package mcu_dec_pkg;

  typedef enum logic [4:0] {
    KIND_RET   = 5'd0,
    KIND_ADIW  = 5'd1,
    KIND_SBIW  = 5'd2,
    KIND_CP    = 5'd3,
    KIND_CPC   = 5'd4,
    KIND_ADD   = 5'd5,
    KIND_ADC   = 5'd6,
    KIND_EOR   = 5'd7,
    KIND_LDI   = 5'd8,
    KIND_CPI   = 5'd9,
    KIND_RJMP  = 5'd10,
    KIND_RCALL = 5'd11,
    KIND_BRGE  = 5'd12,
    KIND_BRNE  = 5'd13,
    KIND_IN    = 5'd14,
    KIND_OUT   = 5'd15,
    KIND_CALL  = 5'd16,
    KIND_JMP   = 5'd17,
    KIND_STS   = 5'd18,
    KIND_LDS   = 5'd19,
    KIND_LPM   = 5'd20,
    KIND_STX   = 5'd21,
    KIND_PUSH  = 5'd22,
    KIND_POP   = 5'd23
  } kind_t;

  typedef struct packed {
    logic [15:0] instruction_word;
    logic [15:0] next_word;
  } instr_t;

  typedef struct packed {
    logic               invalid;
    kind_t              kind;
    logic [1:0]         length_words;
    logic [4:0]         first_register;
    logic [4:0]         second_register;
    logic [1:0]         pair_index;
    logic [7:0]         immediate;
    logic signed [11:0] relative_offset;
    logic [5:0]         io_address;
    logic [15:0]        absolute_address;
  } decoded_t;

  localparam logic [15:0] MASK_BYTE   = 16'hFF00;
  localparam logic [15:0] MASK_ALU    = 16'hFC00;
  localparam logic [15:0] MASK_NIBBLE = 16'hF000;
  localparam logic [15:0] MASK_BRANCH = 16'hFC07;
  localparam logic [15:0] MASK_IO     = 16'hF800;
  localparam logic [15:0] MASK_JUMP   = 16'hFE0E;
  localparam logic [15:0] MASK_LDST   = 16'hFE0F;

  localparam logic [15:0] OP_RET   = 16'h9508;
  localparam logic [15:0] OP_ADIW  = 16'h9600;
  localparam logic [15:0] OP_SBIW  = 16'h9700;
  localparam logic [15:0] OP_CP    = 16'h1400;
  localparam logic [15:0] OP_CPC   = 16'h0400;
  localparam logic [15:0] OP_ADD   = 16'h0C00;
  localparam logic [15:0] OP_ADC   = 16'h1C00;
  localparam logic [15:0] OP_EOR   = 16'h2400;
  localparam logic [15:0] OP_LDI   = 16'hE000;
  localparam logic [15:0] OP_CPI   = 16'h3000;
  localparam logic [15:0] OP_RJMP  = 16'hC000;
  localparam logic [15:0] OP_RCALL = 16'hD000;
  localparam logic [15:0] OP_BRGE  = 16'hF404;
  localparam logic [15:0] OP_BRNE  = 16'hF401;
  localparam logic [15:0] OP_IN    = 16'hB000;
  localparam logic [15:0] OP_OUT   = 16'hB800;
  localparam logic [15:0] OP_CALL  = 16'h940E;
  localparam logic [15:0] OP_JMP   = 16'h940C;
  localparam logic [15:0] OP_STS   = 16'h9200;
  localparam logic [15:0] OP_LDS   = 16'h9000;
  localparam logic [15:0] OP_LPM   = 16'h9004;
  localparam logic [15:0] OP_STX   = 16'h920C;
  localparam logic [15:0] OP_PUSH  = 16'h920F;
  localparam logic [15:0] OP_POP   = 16'h900F;

  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;

endpackage

// ----- rtl/core/mcu_dec_logic.sv -----
// Combinational decode of one instruction word and its following word.
`timescale 1ns / 1ps

module mcu_dec_logic (
  input  mcu_dec_pkg::instr_t   instr,
  output mcu_dec_pkg::decoded_t dec
);

  logic [15:0] w;
  logic [15:0] m_byte;
  logic [15:0] m_alu;
  logic [15:0] m_nib;
  logic [15:0] m_br;
  logic [15:0] m_io;
  logic [15:0] m_jmp;
  logic [15:0] m_ldst;

  assign w      = instr.instruction_word;
  assign m_byte = w & mcu_dec_pkg::MASK_BYTE;
  assign m_alu  = w & mcu_dec_pkg::MASK_ALU;
  assign m_nib  = w & mcu_dec_pkg::MASK_NIBBLE;
  assign m_br   = w & mcu_dec_pkg::MASK_BRANCH;
  assign m_io   = w & mcu_dec_pkg::MASK_IO;
  assign m_jmp  = w & mcu_dec_pkg::MASK_JUMP;
  assign m_ldst = w & mcu_dec_pkg::MASK_LDST;

  // Encodings are tried in a fixed priority order; the first match wins.
  always_comb begin
    dec = '0;
    dec.kind = mcu_dec_pkg::KIND_RET;
    dec.length_words = mcu_dec_pkg::LEN_ONE;
    if (w == mcu_dec_pkg::OP_RET) begin
      dec.kind = mcu_dec_pkg::KIND_RET;
    end else if (m_byte == mcu_dec_pkg::OP_ADIW || m_byte == mcu_dec_pkg::OP_SBIW) begin
      dec.kind = (m_byte == mcu_dec_pkg::OP_ADIW) ? mcu_dec_pkg::KIND_ADIW
                                                  : mcu_dec_pkg::KIND_SBIW;
      dec.pair_index = w[5:4];
      dec.immediate  = {2'b00, w[7:6], w[3:0]};
    end else if (m_alu == mcu_dec_pkg::OP_CP || m_alu == mcu_dec_pkg::OP_CPC ||
                 m_alu == mcu_dec_pkg::OP_ADD || m_alu == mcu_dec_pkg::OP_ADC ||
                 m_alu == mcu_dec_pkg::OP_EOR) begin
      case (m_alu)
        mcu_dec_pkg::OP_CP:  dec.kind = mcu_dec_pkg::KIND_CP;
        mcu_dec_pkg::OP_CPC: dec.kind = mcu_dec_pkg::KIND_CPC;
        mcu_dec_pkg::OP_ADD: dec.kind = mcu_dec_pkg::KIND_ADD;
        mcu_dec_pkg::OP_ADC: dec.kind = mcu_dec_pkg::KIND_ADC;
        default:             dec.kind = mcu_dec_pkg::KIND_EOR;
      endcase
      dec.first_register  = {w[9], w[3:0]};
      dec.second_register = w[8:4];
    end else if (m_nib == mcu_dec_pkg::OP_LDI || m_nib == mcu_dec_pkg::OP_CPI) begin
      dec.kind = (m_nib == mcu_dec_pkg::OP_LDI) ? mcu_dec_pkg::KIND_LDI
                                                : mcu_dec_pkg::KIND_CPI;
      dec.immediate      = {w[11:8], w[3:0]};
      dec.first_register = {1'b1, w[7:4]};
    end else if (m_nib == mcu_dec_pkg::OP_RJMP || m_nib == mcu_dec_pkg::OP_RCALL) begin
      dec.kind = (m_nib == mcu_dec_pkg::OP_RJMP) ? mcu_dec_pkg::KIND_RJMP
                                                 : mcu_dec_pkg::KIND_RCALL;
      dec.relative_offset = w[11:0];
    end else if (m_br == mcu_dec_pkg::OP_BRGE || m_br == mcu_dec_pkg::OP_BRNE) begin
      dec.kind = (m_br == mcu_dec_pkg::OP_BRGE) ? mcu_dec_pkg::KIND_BRGE
                                                : mcu_dec_pkg::KIND_BRNE;
      dec.relative_offset = {{5{w[9]}}, w[9:3]};
    end else if (m_io == mcu_dec_pkg::OP_IN || m_io == mcu_dec_pkg::OP_OUT) begin
      dec.kind = (m_io == mcu_dec_pkg::OP_IN) ? mcu_dec_pkg::KIND_IN
                                              : mcu_dec_pkg::KIND_OUT;
      dec.io_address     = {w[10:9], w[3:0]};
      dec.first_register = w[8:4];
    end else if (m_jmp == mcu_dec_pkg::OP_CALL || m_jmp == mcu_dec_pkg::OP_JMP) begin
      dec.kind = (m_jmp == mcu_dec_pkg::OP_CALL) ? mcu_dec_pkg::KIND_CALL
                                                 : mcu_dec_pkg::KIND_JMP;
      dec.length_words     = mcu_dec_pkg::LEN_TWO;
      dec.absolute_address = instr.next_word;
    end else if (m_ldst == mcu_dec_pkg::OP_STS || m_ldst == mcu_dec_pkg::OP_LDS) begin
      dec.kind = (m_ldst == mcu_dec_pkg::OP_STS) ? mcu_dec_pkg::KIND_STS
                                                 : mcu_dec_pkg::KIND_LDS;
      dec.length_words     = mcu_dec_pkg::LEN_TWO;
      dec.first_register   = w[8:4];
      dec.absolute_address = instr.next_word;
    end else if (m_ldst == mcu_dec_pkg::OP_LPM || m_ldst == mcu_dec_pkg::OP_STX ||
                 m_ldst == mcu_dec_pkg::OP_PUSH || m_ldst == mcu_dec_pkg::OP_POP) begin
      case (m_ldst)
        mcu_dec_pkg::OP_LPM:  dec.kind = mcu_dec_pkg::KIND_LPM;
        mcu_dec_pkg::OP_STX:  dec.kind = mcu_dec_pkg::KIND_STX;
        mcu_dec_pkg::OP_PUSH: dec.kind = mcu_dec_pkg::KIND_PUSH;
        default:              dec.kind = mcu_dec_pkg::KIND_POP;
      endcase
      dec.first_register = w[8:4];
    end else begin
      dec.invalid      = 1'b1;
      dec.kind         = mcu_dec_pkg::KIND_RET;
      dec.length_words = mcu_dec_pkg::LEN_NONE;
    end
  end

endmodule

// ----- rtl/core/mcu_instruction_decoder_core.sv -----
// Top level of the instruction decoder: input register, decode logic and result register.
//
//   Channel   Direction  Handshake                  Payload
//   instr     in         instr_valid / instr_ready  instr (mcu_dec_pkg::instr_t)
//   dec       out        dec_valid / dec_ready      dec (mcu_dec_pkg::decoded_t)
//
// Each item passes an input register and then a result register that presents its result.
// One item is accepted every cycle while the output side takes results.
// A stalled output holds both stages, and a stage frees when it hands its item on.
// Reset clears the stage valid flags only.
`timescale 1ns / 1ps

module mcu_instruction_decoder_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  instr_valid,
  output logic                  instr_ready,
  input  mcu_dec_pkg::instr_t   instr,
  output logic                  dec_valid,
  input  logic                  dec_ready,
  output mcu_dec_pkg::decoded_t dec
);

  logic                  stage_valid;
  mcu_dec_pkg::instr_t   stage_instr;
  logic                  stage_ready;
  mcu_dec_pkg::decoded_t dec_next;

  assign stage_ready = !dec_valid || dec_ready;
  assign instr_ready = !stage_valid || stage_ready;

  mcu_dec_logic u_logic (
    .instr (stage_instr),
    .dec   (dec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      dec_valid   <= 1'b0;
    end else begin
      if (instr_ready) begin
        stage_valid <= instr_valid;
      end
      if (stage_ready) begin
        dec_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (instr_ready && instr_valid) begin
      stage_instr <= instr;
    end
    if (stage_ready && stage_valid) begin
      dec <= dec_next;
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the instruction decoder core with randomized handshakes.
`timescale 1ns / 1ps

module tb;
  import mcu_dec_pkg::*;

  class decode_scoreboard;
    typedef struct {
      instr_t   src;
      decoded_t want;
    } pending_t;

    pending_t    pending_decodes[$];
    int unsigned errors;
    int unsigned results_checked;
    int unsigned unmatched_seen;
    bit [23:0]   kinds_seen;

    function new();
      errors = 0;
      results_checked = 0;
      unmatched_seen = 0;
      kinds_seen = '0;
    endfunction

    function decoded_t predict_decode(instr_t item);
      decoded_t    d;
      logic [15:0] w;
      logic [15:0] mb, ma, mn, mr, mi, mj, ml;
      w  = item.instruction_word;
      mb = w & MASK_BYTE;
      ma = w & MASK_ALU;
      mn = w & MASK_NIBBLE;
      mr = w & MASK_BRANCH;
      mi = w & MASK_IO;
      mj = w & MASK_JUMP;
      ml = w & MASK_LDST;
      d = '0;
      d.length_words = LEN_ONE;
      if (w == OP_RET) begin
        d.kind = KIND_RET;
      end else if (mb == OP_ADIW || mb == OP_SBIW) begin
        d.kind = (mb == OP_ADIW) ? KIND_ADIW : KIND_SBIW;
        d.pair_index = w[5:4];
        d.immediate = {2'b00, w[7:6], w[3:0]};
      end else if (ma == OP_CP || ma == OP_CPC || ma == OP_ADD || ma == OP_ADC ||
                   ma == OP_EOR) begin
        d.kind = (ma == OP_CP) ? KIND_CP : (ma == OP_CPC) ? KIND_CPC :
                 (ma == OP_ADD) ? KIND_ADD : (ma == OP_ADC) ? KIND_ADC : KIND_EOR;
        d.first_register = {w[9], w[3:0]};
        d.second_register = w[8:4];
      end else if (mn == OP_LDI || mn == OP_CPI) begin
        d.kind = (mn == OP_LDI) ? KIND_LDI : KIND_CPI;
        d.immediate = {w[11:8], w[3:0]};
        d.first_register = {1'b1, w[7:4]};
      end else if (mn == OP_RJMP || mn == OP_RCALL) begin
        d.kind = (mn == OP_RJMP) ? KIND_RJMP : KIND_RCALL;
        d.relative_offset = w[11:0];
      end else if (mr == OP_BRGE || mr == OP_BRNE) begin
        d.kind = (mr == OP_BRGE) ? KIND_BRGE : KIND_BRNE;
        d.relative_offset = {{5{w[9]}}, w[9:3]};
      end else if (mi == OP_IN || mi == OP_OUT) begin
        d.kind = (mi == OP_IN) ? KIND_IN : KIND_OUT;
        d.io_address = {w[10:9], w[3:0]};
        d.first_register = w[8:4];
      end else if (mj == OP_CALL || mj == OP_JMP) begin
        d.kind = (mj == OP_CALL) ? KIND_CALL : KIND_JMP;
        d.length_words = LEN_TWO;
        d.absolute_address = item.next_word;
      end else if (ml == OP_STS || ml == OP_LDS) begin
        d.kind = (ml == OP_STS) ? KIND_STS : KIND_LDS;
        d.length_words = LEN_TWO;
        d.first_register = w[8:4];
        d.absolute_address = item.next_word;
      end else if (ml == OP_LPM || ml == OP_STX || ml == OP_PUSH || ml == OP_POP) begin
        d.kind = (ml == OP_LPM) ? KIND_LPM : (ml == OP_STX) ? KIND_STX :
                 (ml == OP_PUSH) ? KIND_PUSH : KIND_POP;
        d.first_register = w[8:4];
      end else begin
        d.invalid = 1'b1;
        d.kind = KIND_RET;
        d.length_words = LEN_NONE;
      end
      return d;
    endfunction

    function void note_instr(instr_t item);
      pending_t p;
      p.src = item;
      p.want = predict_decode(item);
      pending_decodes.push_back(p);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got,
                                instr_t src);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch in %s for word %h/%h: expected %h, got %h",
                   name, src.instruction_word, src.next_word, want, got);
      end
    endfunction

    function void check_decode(decoded_t got);
      pending_t p;
      if (pending_decodes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result with nothing pending: %h", got);
        return;
      end
      p = pending_decodes.pop_front();
      results_checked++;
      if (p.want.invalid) unmatched_seen++;
      else kinds_seen[p.want.kind] = 1'b1;
      compare_field("invalid", p.want.invalid, got.invalid, p.src);
      compare_field("kind", p.want.kind, got.kind, p.src);
      compare_field("length_words", p.want.length_words, got.length_words, p.src);
      compare_field("first_register", p.want.first_register, got.first_register, p.src);
      compare_field("second_register", p.want.second_register, got.second_register,
                    p.src);
      compare_field("pair_index", p.want.pair_index, got.pair_index, p.src);
      compare_field("immediate", p.want.immediate, got.immediate, p.src);
      compare_field("relative_offset", p.want.relative_offset, got.relative_offset,
                    p.src);
      compare_field("io_address", p.want.io_address, got.io_address, p.src);
      compare_field("absolute_address", p.want.absolute_address, got.absolute_address,
                    p.src);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     instr_valid;
  logic     instr_ready;
  instr_t   instr;
  logic     dec_valid;
  logic     dec_ready;
  decoded_t dec;

  decode_scoreboard board = new();
  int unsigned      items_sent = 0;
  int               tx_level = 1;
  int               rx_level = 1;
  int               hold_requests = 0;

  mcu_instruction_decoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .instr_valid(instr_valid),
    .instr_ready(instr_ready),
    .instr      (instr),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec        (dec)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(int level);
    int r;
    if (level == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic instr_t random_instr();
    logic [15:0] op, mask, w;
    int          r;
    r = $urandom_range(0, 99);
    case (kind_t'($urandom_range(0, 23)))
      KIND_RET:   begin op = OP_RET;   mask = 16'hFFFF;    end
      KIND_ADIW:  begin op = OP_ADIW;  mask = MASK_BYTE;   end
      KIND_SBIW:  begin op = OP_SBIW;  mask = MASK_BYTE;   end
      KIND_CP:    begin op = OP_CP;    mask = MASK_ALU;    end
      KIND_CPC:   begin op = OP_CPC;   mask = MASK_ALU;    end
      KIND_ADD:   begin op = OP_ADD;   mask = MASK_ALU;    end
      KIND_ADC:   begin op = OP_ADC;   mask = MASK_ALU;    end
      KIND_EOR:   begin op = OP_EOR;   mask = MASK_ALU;    end
      KIND_LDI:   begin op = OP_LDI;   mask = MASK_NIBBLE; end
      KIND_CPI:   begin op = OP_CPI;   mask = MASK_NIBBLE; end
      KIND_RJMP:  begin op = OP_RJMP;  mask = MASK_NIBBLE; end
      KIND_RCALL: begin op = OP_RCALL; mask = MASK_NIBBLE; end
      KIND_BRGE:  begin op = OP_BRGE;  mask = MASK_BRANCH; end
      KIND_BRNE:  begin op = OP_BRNE;  mask = MASK_BRANCH; end
      KIND_IN:    begin op = OP_IN;    mask = MASK_IO;     end
      KIND_OUT:   begin op = OP_OUT;   mask = MASK_IO;     end
      KIND_CALL:  begin op = OP_CALL;  mask = MASK_JUMP;   end
      KIND_JMP:   begin op = OP_JMP;   mask = MASK_JUMP;   end
      KIND_STS:   begin op = OP_STS;   mask = MASK_LDST;   end
      KIND_LDS:   begin op = OP_LDS;   mask = MASK_LDST;   end
      KIND_LPM:   begin op = OP_LPM;   mask = MASK_LDST;   end
      KIND_STX:   begin op = OP_STX;   mask = MASK_LDST;   end
      KIND_PUSH:  begin op = OP_PUSH;  mask = MASK_LDST;   end
      default:    begin op = OP_POP;   mask = MASK_LDST;   end
    endcase
    if (r < 80) w = op | (16'($urandom) & ~mask);
    else if (r < 93) w = 16'($urandom);
    else w = (op | (16'($urandom) & ~mask)) ^ (16'd1 << $urandom_range(0, 15));
    return instr_t'{w, 16'($urandom)};
  endfunction

  task automatic send_instr(instr_t item);
    int gap;
    gap = pick_gap(tx_level);
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr <= item;
    do @(posedge clk); while (!instr_ready);
    board.note_instr(item);
    items_sent++;
  endtask

  task automatic send_word(logic [15:0] w, logic [15:0] nw);
    send_instr(instr_t'{w, nw});
  endtask

  initial begin : result_sink
    int stall;
    int served;
    stall = 0;
    served = 0;
    dec_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (dec_valid && dec_ready) begin
        board.check_decode(dec);
        stall = pick_gap(rx_level);
      end
      if (hold_requests != served) begin
        served = hold_requests;
        stall = 400;
      end
      if (stall > 0) begin
        dec_ready <= 1'b0;
        stall--;
      end else begin
        dec_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n;
    rst <= 1'b1;
    instr_valid <= 1'b0;
    instr <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_RET, 16'hFFFF);
    send_word(16'h96FF, 16'h0000);
    send_word(OP_SBIW, 16'hFFFF);
    send_word(16'h17FF, 16'h0000);
    send_word(OP_CPC, 16'hFFFF);
    send_word(16'h0C0F, 16'h0000);
    send_word(16'h1DF0, 16'hFFFF);
    send_word(16'h27FF, 16'h0000);
    send_word(16'hEFFF, 16'hFFFF);
    send_word(OP_CPI, 16'h0000);
    send_word(16'hC7FF, 16'hFFFF);
    send_word(16'hC800, 16'h0000);
    send_word(16'hDFFF, 16'hFFFF);
    send_word(16'hF7FC, 16'h0000);
    send_word(16'hF601, 16'hFFFF);
    send_word(OP_IN, 16'h0000);
    send_word(16'hBFFF, 16'hFFFF);
    send_word(16'h95FF, 16'hFFFF);
    send_word(OP_JMP, 16'h0000);
    send_word(16'h93F0, 16'hFFFF);
    send_word(OP_LDS, 16'h1234);
    send_word(16'h91F4, 16'hFFFF);
    send_word(OP_STX, 16'h0000);
    send_word(16'h93FF, 16'hFFFF);
    send_word(OP_POP, 16'h0000);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h9509, 16'h0000);

    for (n = 0; n < 1900; n++) begin
      if (n % 150 == 0) begin
        tx_level = ($urandom_range(0, 3) != 0);
        rx_level = ($urandom_range(0, 3) != 0);
      end
      if (n == 600 || n == 1400) hold_requests++;
      send_instr(random_instr());
    end
    instr_valid <= 1'b0;

    while (board.pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d instruction items and checked %0d decoded results.",
             items_sent, board.results_checked);
    $display("Decoded %0d of 24 instruction kinds and %0d unmatched words.",
             $countones(board.kinds_seen), board.unmatched_seen);
    if (board.errors == 0 && board.pending_decodes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d results still pending.", board.pending_decodes.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mcu_dec_pkg.sv
rtl/core/mcu_dec_logic.sv
rtl/core/mcu_instruction_decoder_core.sv
tb/tb.sv
